/* rtl/fcm_pkg.sv */
// fcm_pkg: shared types and constants for the fixed capacity multiset
// holds sizing constants, operation codes, result status codes, the back-end sequencer states and the queue status
// depends on nothing
package fcm_pkg;

	localparam int CAP_DEF        = 32;
	localparam int VALUE_BITS_DEF = 32;
	localparam int QUEUE_DEPTH    = 2;
	localparam int MODE_W         = 2;
	localparam int FIELD_W        = 6;

	typedef enum logic [MODE_W-1:0] {
		OP_INSERT    = 2'd0,
		OP_ERASE_ONE = 2'd1,
		OP_ERASE_ALL = 2'd2,
		OP_COUNT     = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_NOMATCH  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_MOVE_RD,
		S_MOVE_WR,
		S_RESULT
	} bstate_t;

	// queue status: full is seen by the front end, vld by the back end
	typedef struct packed {
		logic vld;
		logic full;
	} qstat_t;

endpackage

/* rtl/fcm_front.sv */
// fcm_front: input register that accepts requests and classifies them
// depends on fcm_pkg; feeds fcm_queue
module fcm_front #(
	parameter int VALUE_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [fcm_pkg::MODE_W-1:0]        mode,
	input  logic [31:0]                       value,
	input  fcm_pkg::qstat_t                   qstat,
	output logic                              push,
	output logic [fcm_pkg::MODE_W+VALUE_BITS-1:0] push_data
);
	import fcm_pkg::*;

	logic                  vld_s1;
	op_t                   op_s1;
	logic [VALUE_BITS-1:0] val_s1;
	logic                  take;

	assign in_stall  = vld_s1 && qstat.full;
	assign take      = in_valid && !in_stall;
	assign push      = vld_s1 && !qstat.full;
	assign push_data = {op_s1, val_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

	// bits above VALUE_BITS are dropped, configurations wider than 32 bits zero-extend
	always_ff @(posedge clk) begin
		if (take) begin
			op_s1  <= op_t'(mode);
			val_s1 <= VALUE_BITS'(value);
		end
	end

endmodule

/* rtl/fcm_queue.sv */
// fcm_queue: short request queue between the front and back ends
// depends on fcm_pkg
module fcm_queue #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output fcm_pkg::qstat_t  qstat,
	output logic [WIDTH-1:0] pop_data
);
	import fcm_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign qstat.vld  = (cnt_q != '0);
	assign qstat.full = (cnt_q == CW'(DEPTH));
	assign do_push    = push && !qstat.full;
	assign do_pop     = pop && qstat.vld;
	assign pop_data   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* rtl/fcm_back.sv */
// fcm_back: entry store and sequencer that carries out each request
// scans the store one entry per cycle through a registered read port
// depends on fcm_pkg; drives the output register
module fcm_back #(
	parameter int CAP        = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  fcm_pkg::qstat_t                        qstat,
	input  logic [fcm_pkg::MODE_W+VALUE_BITS-1:0]  pop_data,
	output logic                                   pop,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [1:0]                             status,
	output logic [fcm_pkg::FIELD_W-1:0]            match_count,
	output logic [fcm_pkg::FIELD_W-1:0]            fill_level
);
	import fcm_pkg::*;

	localparam int AW = (CAP > 1) ? $clog2(CAP) : 1;
	localparam int CW = $clog2(CAP + 1);

	logic [VALUE_BITS-1:0] mem [CAP];

	bstate_t               state_q, state_d;
	op_t                   op_q, op_d;
	logic [VALUE_BITS-1:0] val_q, val_d;
	logic [CW-1:0]         fill_q, fill_d;
	logic [CW-1:0]         scan_q, scan_d;
	logic [CW-1:0]         keep_q, keep_d;
	logic [CW-1:0]         match_q, match_d;
	logic [AW-1:0]         hit_q, hit_d;
	logic [AW-1:0]         cmp_idx_q, cmp_idx_d;
	logic                  cmp_vld_q, cmp_vld_d;
	status_t               res_q, res_d;
	logic [VALUE_BITS-1:0] rd_data_q;

	logic                  out_vld_q, out_vld_d;
	logic [1:0]            out_status_q, out_status_d;
	logic [FIELD_W-1:0]    out_match_q, out_match_d;
	logic [FIELD_W-1:0]    out_fill_q, out_fill_d;

	logic [AW-1:0]         rd_addr;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [VALUE_BITS-1:0] wr_data;
	logic [CW-1:0]         last_idx;
	logic                  hit;
	op_t                   q_op;
	logic [VALUE_BITS-1:0] q_val;

	assign q_op     = op_t'(pop_data[MODE_W+VALUE_BITS-1:VALUE_BITS]);
	assign q_val    = pop_data[VALUE_BITS-1:0];
	assign last_idx = fill_q - 1'b1;
	assign hit      = cmp_vld_q && (rd_data_q == val_q);

	assign out_valid   = out_vld_q;
	assign status      = out_status_q;
	assign match_count = out_match_q;
	assign fill_level  = out_fill_q;

	always_comb begin
		state_d      = state_q;
		op_d         = op_q;
		val_d        = val_q;
		fill_d       = fill_q;
		scan_d       = scan_q;
		keep_d       = keep_q;
		match_d      = match_q;
		hit_d        = hit_q;
		cmp_idx_d    = cmp_idx_q;
		cmp_vld_d    = 1'b0;
		res_d        = res_q;
		pop          = 1'b0;
		rd_addr      = scan_q[AW-1:0];
		wr_en        = 1'b0;
		wr_addr      = keep_q[AW-1:0];
		wr_data      = rd_data_q;
		out_vld_d    = out_vld_q && out_stall;
		out_status_d = out_status_q;
		out_match_d  = out_match_q;
		out_fill_d   = out_fill_q;

		case (state_q)
			S_IDLE: begin
				if (qstat.vld) begin
					pop     = 1'b1;
					op_d    = q_op;
					val_d   = q_val;
					scan_d  = '0;
					keep_d  = '0;
					match_d = '0;
					res_d   = ST_DONE;
					if (q_op == OP_INSERT) begin
						if (fill_q == CW'(CAP)) begin
							res_d = ST_OVERFLOW;
						end else begin
							wr_en   = 1'b1;
							wr_addr = fill_q[AW-1:0];
							wr_data = q_val;
							fill_d  = fill_q + 1'b1;
						end
						state_d = S_RESULT;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				// read entry scan_q now, compare the entry read last cycle
				if (scan_q < fill_q) begin
					cmp_vld_d = 1'b1;
					cmp_idx_d = scan_q[AW-1:0];
					scan_d    = scan_q + 1'b1;
				end
				if (cmp_vld_q) begin
					case (op_q)
						OP_ERASE_ONE: begin
							if (hit) begin
								hit_d     = cmp_idx_q;
								match_d   = CW'(1);
								cmp_vld_d = 1'b0;
								state_d   = S_MOVE_RD;
							end
						end
						OP_ERASE_ALL: begin
							// survivors are compacted down to keep_q
							if (hit) begin
								match_d = match_q + 1'b1;
							end else begin
								wr_en  = 1'b1;
								keep_d = keep_q + 1'b1;
							end
						end
						OP_COUNT: begin
							if (hit) begin
								match_d = match_q + 1'b1;
							end
						end
						default: begin
						end
					endcase
				end else if (scan_q == fill_q) begin
					case (op_q)
						OP_ERASE_ONE: res_d  = ST_NOMATCH;
						OP_ERASE_ALL: fill_d = keep_q;
						default: begin
						end
					endcase
					state_d = S_RESULT;
				end
			end
			S_MOVE_RD: begin
				rd_addr = last_idx[AW-1:0];
				state_d = S_MOVE_WR;
			end
			S_MOVE_WR: begin
				// last entry fills the hole
				wr_en   = 1'b1;
				wr_addr = hit_q;
				fill_d  = last_idx;
				state_d = S_RESULT;
			end
			S_RESULT: begin
				if (!out_vld_q || !out_stall) begin
					out_vld_d    = 1'b1;
					out_status_d = res_q;
					out_match_d  = FIELD_W'(match_q);
					out_fill_d   = FIELD_W'(fill_q);
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			cmp_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			fill_q    <= fill_d;
			cmp_vld_q <= cmp_vld_d;
			out_vld_q <= out_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q         <= op_d;
		val_q        <= val_d;
		scan_q       <= scan_d;
		keep_q       <= keep_d;
		match_q      <= match_d;
		hit_q        <= hit_d;
		cmp_idx_q    <= cmp_idx_d;
		res_q        <= res_d;
		out_status_q <= out_status_d;
		out_match_q  <= out_match_d;
		out_fill_q   <= out_fill_d;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

endmodule

/* rtl/fixed_capacity_multiset.sv */
// fixed_capacity_multiset: an unordered bag of up to CAP values
// request channel: in_valid/in_stall with mode and value; result channel:
// out_valid/out_stall with status, match_count and fill_level, one result
// per request, in request order.
// insert appends (or reports overflow when full), erase-one moves the last
// entry into the first matching slot, erase-all removes every match and compacts
// the rest, count tallies matches; fill_level is the size after the request.
// the front end registers a request and hands it to a two-entry queue; the
// back end scans the entry store one entry per cycle through its single
// registered read port, so that scan sets the rate.
// a request passes the input register and the queue to the back end, which
// takes it in S_IDLE: insert goes straight to S_RESULT, count and erase-all
// scan every entry, erase-one stops at the first match and moves the last entry.
// the back end works on one request at a time and pops the next only when idle.
// requests keep being accepted while the back end works, until the queue
// and the input register are full.
// a result waits in the output register while out_stall is high; the back
// end holds its next result until that register frees up.
// reset empties the store and clears the queue and output valid; stored words are not cleared
// depends on fcm_pkg, fcm_front, fcm_queue, fcm_back
module fixed_capacity_multiset #(
	parameter int CAP        = fcm_pkg::CAP_DEF,
	parameter int VALUE_BITS = fcm_pkg::VALUE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [fcm_pkg::MODE_W-1:0]  mode,
	input  logic [31:0]                 value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  status,
	output logic [fcm_pkg::FIELD_W-1:0] match_count,
	output logic [fcm_pkg::FIELD_W-1:0] fill_level
);
	import fcm_pkg::*;

	localparam int QW = MODE_W + VALUE_BITS;

	qstat_t          qstat;
	logic            push;
	logic [QW-1:0]   push_data;
	logic            pop;
	logic [QW-1:0]   pop_data;

	fcm_front #(
		.VALUE_BITS(VALUE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.value     (value),
		.qstat     (qstat),
		.push      (push),
		.push_data (push_data)
	);

	fcm_queue #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.qstat     (qstat),
		.pop_data  (pop_data)
	);

	fcm_back #(
		.CAP       (CAP),
		.VALUE_BITS(VALUE_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.qstat       (qstat),
		.pop_data    (pop_data),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.match_count (match_count),
		.fill_level  (fill_level)
	);

endmodule

/* rtl/fcm_checker.sv */
// fcm_checker: port-level checks on the multiset results over time
// depends on fcm_pkg; bound to fixed_capacity_multiset below
module fcm_checker #(
	parameter int CAP = fcm_pkg::CAP_DEF
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [1:0]                  status,
	input logic [fcm_pkg::FIELD_W-1:0] match_count,
	input logic [fcm_pkg::FIELD_W-1:0] fill_level
);
	import fcm_pkg::*;

	localparam logic [FIELD_W-1:0] CAP_F = FIELD_W'(CAP);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status)
			&& $stable(match_count) && $stable(fill_level))
		else $error("result changed while stalled");

	// overflow only on a full store, nothing matched
	a_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_OVERFLOW) |-> (match_count == '0) && (fill_level == CAP_F))
		else $error("overflow result inconsistent");

	// a failed erase-one removes nothing
	a_nomatch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_NOMATCH) |-> (match_count == '0))
		else $error("no-match result reports a match");

	// size never exceeds capacity (checked only when CAP is below 64)
	a_fill_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (CAP >= 64) || (fill_level <= CAP_F))
		else $error("fill level above capacity");

	// output valid is low after an edge with reset held
	a_reset: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("output valid during reset");

endmodule

bind fixed_capacity_multiset fcm_checker #(.CAP(CAP)) u_fcm_checker (.*);

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// tb_top: self-checking bench for fixed_capacity_multiset with a bag predictor and scoreboard
// drives mode/value requests and checks status, match_count and fill_level in order
// depends on fcm_pkg and the fixed_capacity_multiset rtl
module tb_top;
	import fcm_pkg::*;

	localparam int CAP         = CAP_DEF;
	localparam int ITEM_TARGET = 1500;
	localparam int CYCLE_LIMIT = 600000;
	localparam int IDLE_PCT    = 14;
	localparam int TAIL_CYCLES = 40;

	typedef struct {
		status_t          status;
		logic [FIELD_W-1:0] hits;
		logic [FIELD_W-1:0] fill;
	} bag_result_t;

	class multiset_scoreboard;
		logic [31:0] bag[$];
		bag_result_t owed[$];
		int          errors;

		function new();
			errors = 0;
		endfunction

		// predicts the result of one accepted request and updates the bag
		function void note_request(op_t op, logic [31:0] val);
			bag_result_t r;
			logic [31:0] kept[$];
			int          hit;
			int          n;
			r.status  = ST_DONE;
			r.hits    = '0;
			n = 0;
			case (op)
				OP_INSERT: begin
					if (bag.size() >= CAP)
						r.status = ST_OVERFLOW;
					else
						bag.push_back(val);
				end
				OP_ERASE_ONE: begin
					hit = -1;
					for (int i = 0; i < bag.size(); i++) begin
						if (bag[i] == val) begin
							hit = i;
							break;
						end
					end
					if (hit < 0) begin
						r.status = ST_NOMATCH;
					end else begin
						bag[hit] = bag[bag.size() - 1];
						void'(bag.pop_back());
						r.hits = 1;
					end
				end
				OP_ERASE_ALL: begin
					foreach (bag[i]) begin
						if (bag[i] == val)
							n++;
						else
							kept.push_back(bag[i]);
					end
					bag = kept;
					r.hits = n[FIELD_W-1:0];
				end
				default: begin
					foreach (bag[i])
						if (bag[i] == val)
							n++;
					r.hits = n[FIELD_W-1:0];
				end
			endcase
			n = bag.size();
			r.fill = n[FIELD_W-1:0];
			owed.push_back(r);
		endfunction

		function void check_result(logic [1:0] st, logic [FIELD_W-1:0] mc,
				logic [FIELD_W-1:0] fl);
			bag_result_t r;
			if (owed.size() == 0) begin
				$error("result with nothing outstanding: status %0d match_count %0d fill_level %0d",
					st, mc, fl);
				errors++;
				return;
			end
			r = owed.pop_front();
			if (st !== r.status) begin
				$error("status: expected %0d, got %0d", r.status, st);
				errors++;
			end
			if (mc !== r.hits) begin
				$error("match_count: expected %0d, got %0d", r.hits, mc);
				errors++;
			end
			if (fl !== r.fill) begin
				$error("fill_level: expected %0d, got %0d", r.fill, fl);
				errors++;
			end
		endfunction

		function int pending();
			return owed.size();
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [MODE_W-1:0]  mode = OP_INSERT;
	logic [31:0]        value = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         status;
	logic [FIELD_W-1:0] match_count;
	logic [FIELD_W-1:0] fill_level;

	multiset_scoreboard sb;
	bit                 calm = 1'b0;
	int                 cycles = 0;

	fixed_capacity_multiset u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.match_count(match_count),
		.fill_level (fill_level)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// result side: check each transaction, then pick the stall for the next edge
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(status, match_count, fill_level);
		out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
	end

	task automatic send_request(op_t op, logic [31:0] val);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode     <= op;
		value    <= val;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_request(op, val);
	endtask

	// stop sending and wait for every outstanding result
	task automatic hold_until_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	function automatic op_t pick_op(int ins_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < ins_pct)
			return OP_INSERT;
		r = $urandom_range(0, 99);
		if (r < 40)
			return OP_ERASE_ONE;
		if (r < 60)
			return OP_ERASE_ALL;
		return OP_COUNT;
	endfunction

	initial begin
		logic [31:0] pool[8];
		int          pool_n;
		int          ins_pct;
		int          phase_len;
		int          phase;
		int          sent;
		int          pct_choice[7];
		sb = new();
		pct_choice = '{95, 80, 60, 50, 40, 20, 5};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty store, duplicates, misses, erase-all with the last entry matching
		send_request(OP_COUNT, 32'h0000_0000);
		send_request(OP_ERASE_ONE, 32'hFFFF_FFFF);
		send_request(OP_ERASE_ALL, 32'h0000_0000);
		send_request(OP_INSERT, 32'h0000_0000);
		send_request(OP_INSERT, 32'hFFFF_FFFF);
		send_request(OP_INSERT, 32'hFFFF_FFFF);
		send_request(OP_INSERT, 32'h8000_0000);
		send_request(OP_COUNT, 32'hFFFF_FFFF);
		send_request(OP_ERASE_ONE, 32'h0000_0001);
		send_request(OP_ERASE_ONE, 32'hFFFF_FFFF);
		send_request(OP_ERASE_ALL, 32'h0000_0000);
		send_request(OP_COUNT, 32'h8000_0000);
		send_request(OP_ERASE_ALL, 32'hFFFF_FFFF);
		send_request(OP_ERASE_ONE, 32'h8000_0000);
		send_request(OP_INSERT, 32'h5A5A_0F0F);
		send_request(OP_INSERT, 32'h0000_0001);
		send_request(OP_INSERT, 32'h5A5A_0F0F);
		send_request(OP_INSERT, 32'h5A5A_0F0F);
		send_request(OP_ERASE_ALL, 32'h5A5A_0F0F);
		send_request(OP_COUNT, 32'h0000_0001);
		send_request(OP_ERASE_ONE, 32'h0000_0001);

		sent  = 0;
		phase = 0;
		pool[0] = $urandom();
		pool_n  = 1;
		while (sent < ITEM_TARGET) begin
			if (phase == 0) begin
				// mostly one value (a random one in ten requests) until full and then overflow
				ins_pct   = 100;
				phase_len = 40;
			end else if (phase == 1) begin
				ins_pct   = 0;
				phase_len = 12;
			end else begin
				pool_n = 1 << $urandom_range(0, 3);
				for (int i = 0; i < 8; i++) begin
					case ($urandom_range(0, 9))
						0:       pool[i] = 32'h0000_0000;
						1:       pool[i] = 32'hFFFF_FFFF;
						default: pool[i] = $urandom();
					endcase
				end
				ins_pct   = pct_choice[$urandom_range(0, 6)];
				phase_len = $urandom_range(30, 90);
			end
			for (int k = 0; k < phase_len; k++) begin
				calm = (sent >= 500 && sent < 800);
				if ($urandom_range(0, 9) == 0)
					send_request(pick_op(ins_pct), $urandom());
				else
					send_request(pick_op(ins_pct), pool[$urandom_range(0, pool_n - 1)]);
				sent++;
			end
			if (phase == 8)
				hold_until_drained();
			phase++;
		end

		calm = 1'b0;
		hold_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

/* sim.f */
rtl/fcm_pkg.sv
rtl/fcm_front.sv
rtl/fcm_queue.sv
rtl/fcm_back.sv
rtl/fixed_capacity_multiset.sv
rtl/fcm_checker.sv
dv/tb_top.sv
